@@ sv/unsigned_integer_text_parser_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the unsigned integer text parser
// Same-cycle and next-cycle implication checks, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef UNSIGNED_INTEGER_TEXT_PARSER_ASSERT_SVH
`define UNSIGNED_INTEGER_TEXT_PARSER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UTP_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("utp assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define UTP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("utp assertion failed");

`endif

@@ sv/utp_pkg.sv @@
// ----------------------------------------------------------------------------
// utp_pkg
// Shared types, constants and character helpers of the text parser.
// ----------------------------------------------------------------------------
package utp_pkg;

  localparam int MAX_TEXT   = 4096;
  localparam int CharW      = 8;
  localparam int BaseW      = 6;
  localparam int NumberW    = 64;
  localparam int OffsetW    = 13;
  localparam int StatusW    = 2;

  localparam logic [BaseW-1:0] BASE_AUTO = 6'd0;
  localparam logic [BaseW-1:0] BASE_MIN  = 6'd2;
  localparam logic [BaseW-1:0] BASE_MAX  = 6'd36;
  localparam logic [BaseW-1:0] BASE_OCT  = 6'd8;
  localparam logic [BaseW-1:0] BASE_DEC  = 6'd10;
  localparam logic [BaseW-1:0] BASE_HEX  = 6'd16;

  localparam logic [CharW-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CharW-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CharW-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CharW-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CharW-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CharW-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CharW-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CharW-1:0] CHAR_UP_A  = 8'h41;
  localparam logic [CharW-1:0] CHAR_UP_X  = 8'h58;
  localparam logic [CharW-1:0] CHAR_UP_Z  = 8'h5A;
  localparam logic [CharW-1:0] CHAR_LO_A  = 8'h61;
  localparam logic [CharW-1:0] CHAR_LO_X  = 8'h78;
  localparam logic [CharW-1:0] CHAR_LO_Z  = 8'h7A;

  localparam logic [StatusW-1:0] STATUS_OK       = 2'd0;
  localparam logic [StatusW-1:0] STATUS_BAD_BASE = 2'd1;
  localparam logic [StatusW-1:0] STATUS_RANGE    = 2'd2;

  typedef enum logic [1:0] {
    BSEL_KEEP,
    BSEL_DEC,
    BSEL_OCT,
    BSEL_HEX
  } base_sel_e;

  typedef struct packed {
    logic      step;
    logic      set_minus;
    base_sel_e base_sel;
    logic      take_digit;
    logic      mark_zero;
    logic      restore_prefix;
    logic      finish;
  } cmd_t;

  typedef struct packed {
    logic radix_bad;
    logic is_space;
    logic is_minus;
    logic is_plus;
    logic is_zero;
    logic is_x;
    logic base_auto;
    logic base_hex;
    logic dig_lt_base;
    logic dig_lt_dec;
    logic dig_lt_oct;
    logic dig_lt_hex;
    logic out_free;
  } stat_t;

  function automatic logic [BaseW-1:0] digit_value(input logic [CharW-1:0] c);
    logic [CharW-1:0] v;
    v = 8'd36;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      v = c - CHAR_ZERO;
    end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
      v = c - CHAR_LO_A + 8'd10;
    end else if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
      v = c - CHAR_UP_A + 8'd10;
    end
    return v[BaseW-1:0];
  endfunction

  function automatic logic base_bad(input logic [BaseW-1:0] b);
    return (b != BASE_AUTO) && ((b < BASE_MIN) || (b > BASE_MAX));
  endfunction

  function automatic logic is_blank(input logic [CharW-1:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

endpackage

@@ sv/utp_ctrl.sv @@
// ----------------------------------------------------------------------------
// utp_ctrl
// Parse phase state machine; issues one command word per cycle.
// ----------------------------------------------------------------------------
module utp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           final_char_i,
  output logic           in_ready_o,
  input  utp_pkg::stat_t st_i,
  output utp_pkg::cmd_t  cmd_o
);

  localparam logic [2:0] PH_SPACE  = 3'd0;
  localparam logic [2:0] PH_SIGN   = 3'd1;
  localparam logic [2:0] PH_ZERO   = 3'd2;
  localparam logic [2:0] PH_X      = 3'd3;
  localparam logic [2:0] PH_DIGITS = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;
  localparam logic [2:0] PH_FINISH = 3'd6;

  logic [2:0] phase_q, phase_d;
  logic [2:0] ph;
  logic       start_num;

  assign in_ready_o = (phase_q != PH_FINISH);

  always_comb begin
    cmd_o          = '0;
    cmd_o.base_sel = utp_pkg::BSEL_KEEP;
    phase_d        = phase_q;
    start_num      = 1'b0;
    ph             = st_i.radix_bad ? PH_DONE : phase_q;
    if (phase_q == PH_FINISH) begin
      if (st_i.out_free) begin
        cmd_o.finish = 1'b1;
        phase_d      = PH_SPACE;
      end
    end else if (in_valid_i) begin
      cmd_o.step = 1'b1;
      unique case (ph)
        PH_SPACE: begin
          if (st_i.is_space) begin
            phase_d = PH_SPACE;
          end else if (st_i.is_minus) begin
            cmd_o.set_minus = 1'b1;
            phase_d         = PH_SIGN;
          end else if (st_i.is_plus) begin
            phase_d = PH_SIGN;
          end else begin
            start_num = 1'b1;
          end
        end
        PH_SIGN: start_num = 1'b1;
        PH_ZERO: begin
          if (st_i.is_x) begin
            phase_d = PH_X;
          end else if (st_i.base_auto) begin
            cmd_o.base_sel = utp_pkg::BSEL_OCT;
            cmd_o.take_digit = st_i.dig_lt_oct;
            phase_d = st_i.dig_lt_oct ? PH_DIGITS : PH_DONE;
          end else begin
            cmd_o.take_digit = st_i.dig_lt_base;
            phase_d = st_i.dig_lt_base ? PH_DIGITS : PH_DONE;
          end
        end
        PH_X: begin
          if (st_i.dig_lt_hex) begin
            cmd_o.base_sel   = utp_pkg::BSEL_HEX;
            cmd_o.take_digit = 1'b1;
            phase_d          = PH_DIGITS;
          end else begin
            cmd_o.restore_prefix = 1'b1;
            phase_d              = PH_DONE;
          end
        end
        PH_DIGITS: begin
          cmd_o.take_digit = st_i.dig_lt_base;
          phase_d = st_i.dig_lt_base ? PH_DIGITS : PH_DONE;
        end
        default: phase_d = PH_DONE;
      endcase

      if (start_num) begin
        if (st_i.is_zero && (st_i.base_auto || st_i.base_hex)) begin
          cmd_o.mark_zero = 1'b1;
          phase_d         = PH_ZERO;
        end else if (st_i.base_auto) begin
          cmd_o.base_sel   = utp_pkg::BSEL_DEC;
          cmd_o.take_digit = st_i.dig_lt_dec;
          phase_d = st_i.dig_lt_dec ? PH_DIGITS : PH_DONE;
        end else begin
          cmd_o.take_digit = st_i.dig_lt_base;
          phase_d = st_i.dig_lt_base ? PH_DIGITS : PH_DONE;
        end
      end

      if (final_char_i) begin
        phase_d = PH_FINISH;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SPACE;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule

@@ sv/utp_datapath.sv @@
// ----------------------------------------------------------------------------
// utp_datapath
// Radix register, accumulator with multiply-add, offsets and result register.
// ----------------------------------------------------------------------------
module utp_datapath #(
  parameter int MaxText = utp_pkg::MAX_TEXT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [utp_pkg::BaseW-1:0]     cfg_radix_i,
  input  logic [utp_pkg::CharW-1:0]     char_code_i,
  input  utp_pkg::cmd_t                 cmd_i,
  output utp_pkg::stat_t                st_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [utp_pkg::NumberW-1:0]   number_o,
  output logic [utp_pkg::OffsetW-1:0]   end_offset_o,
  output logic [utp_pkg::StatusW-1:0]   status_o
);

  localparam int PosW = $clog2(MaxText + 1);
  localparam int NW   = utp_pkg::NumberW;
  localparam int BW   = utp_pkg::BaseW;
  localparam int MacW = NW + BW;
  localparam int OW   = utp_pkg::OffsetW;

  logic [BW-1:0]   radix_q;
  logic [BW-1:0]   base_q, base_d;
  logic [NW-1:0]   acc_q, acc_d;
  logic            ovf_q, ovf_d;
  logic            minus_q, minus_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] dend_q, dend_d;
  logic [PosW-1:0] pzero_q, pzero_d;
  logic            out_valid_q;
  logic [NW-1:0]   number_q, number_d;
  logic [OW-1:0]   offset_q, offset_d;
  logic [utp_pkg::StatusW-1:0] status_q, status_d;

  logic            first;
  logic [BW-1:0]   cur_base, eff_base, dig;
  logic [PosW-1:0] pos_next;
  logic [MacW-1:0] mac;
  logic [PosW+OW-1:0] dend_ext;

  assign first    = (pos_q == '0);
  assign cur_base = first ? radix_q : base_q;
  assign dig      = utp_pkg::digit_value(char_code_i);
  assign pos_next = (pos_q < PosW'(MaxText)) ? pos_q + PosW'(1) : PosW'(MaxText);

  always_comb begin
    unique case (cmd_i.base_sel)
      utp_pkg::BSEL_DEC: eff_base = utp_pkg::BASE_DEC;
      utp_pkg::BSEL_OCT: eff_base = utp_pkg::BASE_OCT;
      utp_pkg::BSEL_HEX: eff_base = utp_pkg::BASE_HEX;
      default:           eff_base = cur_base;
    endcase
  end

  assign mac = MacW'(acc_q) * MacW'(eff_base) + MacW'(dig);

  always_comb begin
    st_o             = '0;
    st_o.radix_bad   = first && utp_pkg::base_bad(radix_q);
    st_o.is_space    = utp_pkg::is_blank(char_code_i);
    st_o.is_minus    = (char_code_i == utp_pkg::CHAR_MINUS);
    st_o.is_plus     = (char_code_i == utp_pkg::CHAR_PLUS);
    st_o.is_zero     = (char_code_i == utp_pkg::CHAR_ZERO);
    st_o.is_x        = (char_code_i == utp_pkg::CHAR_LO_X) ||
                       (char_code_i == utp_pkg::CHAR_UP_X);
    st_o.base_auto   = (cur_base == utp_pkg::BASE_AUTO);
    st_o.base_hex    = (cur_base == utp_pkg::BASE_HEX);
    st_o.dig_lt_base = (cur_base >= utp_pkg::BASE_MIN) && (dig < cur_base);
    st_o.dig_lt_dec  = (dig < utp_pkg::BASE_DEC);
    st_o.dig_lt_oct  = (dig < utp_pkg::BASE_OCT);
    st_o.dig_lt_hex  = (dig < utp_pkg::BASE_HEX);
    st_o.out_free    = !out_valid_q || out_ready_i;
  end

  assign dend_ext = {{OW{1'b0}}, dend_q};

  always_comb begin
    acc_d    = acc_q;
    ovf_d    = ovf_q;
    minus_d  = minus_q;
    base_d   = base_q;
    pos_d    = pos_q;
    dend_d   = dend_q;
    pzero_d  = pzero_q;
    number_d = number_q;
    offset_d = offset_q;
    status_d = status_q;
    if (cmd_i.step) begin
      base_d = eff_base;
      pos_d  = pos_next;
      if (cmd_i.set_minus) begin
        minus_d = 1'b1;
      end
      if (cmd_i.mark_zero) begin
        acc_d   = '0;
        dend_d  = pos_next;
        pzero_d = pos_next;
      end
      if (cmd_i.restore_prefix) begin
        dend_d = pzero_q;
      end
      if (cmd_i.take_digit) begin
        dend_d = pos_next;
        if (mac[MacW-1:NW] != '0) begin
          ovf_d = 1'b1;
        end else begin
          acc_d = mac[NW-1:0];
        end
      end
    end
    if (cmd_i.finish) begin
      priority if (utp_pkg::base_bad(base_q)) begin
        number_d = '0;
        offset_d = '0;
        status_d = utp_pkg::STATUS_BAD_BASE;
      end else if (dend_q == '0) begin
        number_d = '0;
        offset_d = '0;
        status_d = utp_pkg::STATUS_OK;
      end else if (ovf_q) begin
        number_d = '1;
        offset_d = dend_ext[OW-1:0];
        status_d = utp_pkg::STATUS_RANGE;
      end else begin
        number_d = minus_q ? (~acc_q) + NW'(1) : acc_q;
        offset_d = dend_ext[OW-1:0];
        status_d = utp_pkg::STATUS_OK;
      end
      acc_d   = '0;
      ovf_d   = 1'b0;
      minus_d = 1'b0;
      base_d  = '0;
      pos_d   = '0;
      dend_d  = '0;
      pzero_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q     <= '0;
      base_q      <= '0;
      acc_q       <= '0;
      ovf_q       <= 1'b0;
      minus_q     <= 1'b0;
      pos_q       <= '0;
      dend_q      <= '0;
      pzero_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        radix_q <= cfg_radix_i;
      end
      base_q  <= base_d;
      acc_q   <= acc_d;
      ovf_q   <= ovf_d;
      minus_q <= minus_d;
      pos_q   <= pos_d;
      dend_q  <= dend_d;
      pzero_q <= pzero_d;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    number_q <= number_d;
    offset_q <= offset_d;
    status_q <= status_d;
  end

  assign out_valid_o  = out_valid_q;
  assign number_o     = number_q;
  assign end_offset_o = offset_q;
  assign status_o     = status_q;

endmodule

@@ sv/unsigned_integer_text_parser.sv @@
// ----------------------------------------------------------------------------
// unsigned_integer_text_parser
// Streaming text to unsigned 64-bit number parser, one byte per word.
// ----------------------------------------------------------------------------
// Feed the text one byte per word and flag its last byte with final_char_i;
// the parse result then appears as one output word. Ordinary bytes are taken
// at one per cycle, bounded by the single 64x6 multiply-add of the
// accumulator. The final byte is first parsed, then the result is formed into
// the output register in a finish phase, during which in_ready_o is low;
// a result not yet taken holds the finish phase. The radix register is
// sampled at the first byte of each text.
`include "unsigned_integer_text_parser_assert.svh"

module unsigned_integer_text_parser #(
  parameter int MaxText = utp_pkg::MAX_TEXT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [utp_pkg::BaseW-1:0]     cfg_radix_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [utp_pkg::CharW-1:0]     char_code_i,
  input  logic                          final_char_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [utp_pkg::NumberW-1:0]   number_o,
  output logic [utp_pkg::OffsetW-1:0]   end_offset_o,
  output logic [utp_pkg::StatusW-1:0]   status_o
);

  utp_pkg::cmd_t  cmd;
  utp_pkg::stat_t st;

  assign cfg_ready_o = 1'b1;

  utp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .final_char_i(final_char_i),
    .in_ready_o  (in_ready_o),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  utp_datapath #(
    .MaxText(MaxText)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_radix_i (cfg_radix_i),
    .char_code_i (char_code_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .number_o    (number_o),
    .end_offset_o(end_offset_o),
    .status_o    (status_o)
  );

  `UTP_ASSERT_NOW(a_bad_base_zero, clk_i, rst_ni, out_valid_o && (status_o == utp_pkg::STATUS_BAD_BASE), (number_o == '0) && (end_offset_o == '0))
  `UTP_ASSERT_NOW(a_range_all_ones, clk_i, rst_ni, out_valid_o && (status_o == utp_pkg::STATUS_RANGE), number_o == '1)
  `UTP_ASSERT_NEXT(a_final_holds_input, clk_i, rst_ni, in_valid_i && in_ready_o && final_char_i, !in_ready_o)
  `UTP_ASSERT_NOW(a_one_command, clk_i, rst_ni, cmd.finish, !cmd.step)

endmodule
